FILE: rtl/lpog_pkg.sv
//------------------------------------------------------------------------------
// lpog_pkg
// Shared types, constants and the sine table function of the lidar grid.
//------------------------------------------------------------------------------
`default_nettype none

package lpog_pkg;

    localparam int DEF_GRID_WIDTH      = 64;
    localparam int DEF_GRID_HEIGHT     = 64;
    localparam int DEF_TRIG_TABLE_BITS = 10;

    localparam logic [14:0] FULL_Q6  = 15'd23040;
    localparam logic [19:0] INCH_Q24 = 20'd660519;

    localparam logic [31:0] C1 = 32'd1686629713;
    localparam logic [31:0] C3 = 32'd693598668;
    localparam logic [31:0] C5 = 32'd85569306;
    localparam logic [31:0] C7 = 32'd5026994;

    typedef enum logic [1:0] {
        KIND_MEAS    = 2'd0,
        KIND_PUBLISH = 2'd1,
        KIND_READ    = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] angle_raw;
        logic [15:0] distance_raw;
        logic [7:0]  query_x;
        logic [7:0]  query_y;
    } in_item_t;

    typedef struct packed {
        logic       marked;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic       occupied;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_TRIG,
        ST_MUL,
        ST_POS,
        ST_WRITE,
        ST_CLEAR,
        ST_READ
    } state_t;

    // Quarter-wave sine in Q1.15; constant table contents, folded at elaboration.
    function automatic logic [15:0] quarter_sine(input int k, input int qtr);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] q15;
        x   = (64'(k) << 30) / 64'(qtr);
        x2  = (x * x) >> 30;
        p   = 64'(C5) - ((x2 * 64'(C7)) >> 30);
        p   = 64'(C3) - ((x2 * p) >> 30);
        p   = 64'(C1) - ((x2 * p) >> 30);
        s   = (x * p) >> 30;
        q15 = (s + 64'd16384) >> 15;
        if (q15 > 64'd32767)
        begin
            q15 = 64'd32767;
        end
        return q15[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lpog_trig_rom.sv
//------------------------------------------------------------------------------
// lpog_trig_rom
// Registered sine table, one lookup per cycle, in signed Q1.15.
//------------------------------------------------------------------------------
`default_nettype none

module lpog_trig_rom
    import lpog_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = DEF_TRIG_TABLE_BITS
)
(
    input  wire logic                       clk,
    input  wire logic [TRIG_TABLE_BITS-1:0] addr,
    output logic signed [15:0]              data
);

    localparam int N   = 1 << TRIG_TABLE_BITS;
    localparam int QTR = N / 4;

    logic signed [15:0] rom [N];

    // Build the full wave from the quarter wave by symmetry
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            unique case (i / QTR)
                0:       rom[i] = quarter_sine(i % QTR, QTR);
                1:       rom[i] = quarter_sine(QTR - (i % QTR), QTR);
                2:       rom[i] = -quarter_sine(i % QTR, QTR);
                default: rom[i] = -quarter_sine(QTR - (i % QTR), QTR);
            endcase
        end
    end

    // Register the lookup
    always_ff @(posedge clk)
    begin
        data <= rom[addr];
    end

endmodule

`default_nettype wire

FILE: rtl/lpog_grid_mem.sv
//------------------------------------------------------------------------------
// lpog_grid_mem
// Two grid banks with registered read; bank swap publishes, clear sweeps.
// While init is high a clear write goes to both banks.
//------------------------------------------------------------------------------
`default_nettype none

module lpog_grid_mem
    import lpog_pkg::*;
#(
    parameter int AW = 12
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          swap,
    input  wire logic          init,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_data
);

    localparam int DEPTH = 1 << AW;

    logic bank0 [DEPTH];
    logic bank1 [DEPTH];
    logic sel_reg;          // bank that holds the working grid
    logic rd0_reg;
    logic rd1_reg;

    // Track which bank is working
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else if (swap)
        begin
            sel_reg <= ~sel_reg;
        end
    end

    // Write the working bank (both banks during init), read the visible bank
    always_ff @(posedge clk)
    begin
        if (wr_en && (init || !sel_reg))
        begin
            bank0[wr_addr] <= wr_data;
        end
        if (wr_en && (init || sel_reg))
        begin
            bank1[wr_addr] <= wr_data;
        end
        rd0_reg <= bank0[rd_addr];
        rd1_reg <= bank1[rd_addr];
    end

    assign rd_data = sel_reg ? rd0_reg : rd1_reg;

endmodule

`default_nettype wire

FILE: rtl/lidar_polar_occupancy_grid.sv
//------------------------------------------------------------------------------
// lidar_polar_occupancy_grid
// Lidar samples mark an occupancy grid; end of scan publishes it.
//------------------------------------------------------------------------------
// Channel   Direction  Handshake      Payload
// in        input      in_valid/ready in_item_t
// out       output     out_valid/ready out_item_t
//
// Sample: from acceptance to result the steps are angle and distance scale, two
// table lookups, cosine capture, multiplies, floor and write.
// Read: address the visible bank, then take the registered bit.
// Publish, zero distance and unused kind answer in the cycle after acceptance.
// After reset both banks, and after each end of scan the new working bank, are
// cleared one cell per cycle, all 2^AW cells (4096 at the default size), with
// the input held off. A result waits in the output register under stall and
// holds off the next input.
//------------------------------------------------------------------------------
`default_nettype none

module lidar_polar_occupancy_grid
    import lpog_pkg::*;
#(
    parameter int GRID_WIDTH      = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT     = DEF_GRID_HEIGHT,
    parameter int TRIG_TABLE_BITS = DEF_TRIG_TABLE_BITS
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int CELLS = 1 << AW;
    localparam int TB    = TRIG_TABLE_BITS;
    localparam int QTR   = (1 << TB) / 4;

    // FULL_Q6 is 45 * 2^9: shift out 2^9, then multiply by ceil(2^27 / 45)
    localparam int          STEP_SHIFT = 9;
    localparam int          RECIP_BITS = 27;
    localparam logic [21:0] RECIP45    = 22'd2982617;

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [TB-1:0] idx_reg, idx_next;
    logic phase_reg, phase_next;
    logic init_reg, init_next;
    logic signed [15:0] sin_reg, sin_next, cos_reg, cos_next;
    logic [35:0] inch_reg, inch_next;
    logic signed [52:0] px_reg, px_next, py_reg, py_next;
    logic [AW:0] clr_reg, clr_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic [TB-1:0] rom_addr;
    logic signed [15:0] rom_data;
    logic swap, wr_en, wr_data, rd_data;
    logic [AW-1:0] wr_addr, rd_addr;

    logic [14:0] a6, a6r;
    logic [29:0] scaled;
    logic [20:0] step_q;
    logic [42:0] step_prod;
    logic [TB:0] idx_full;
    logic signed [21:0] fx, fy;
    logic signed [21:0] gx, gy;
    logic on_grid;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;

    lpog_trig_rom #(.TRIG_TABLE_BITS(TB)) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    lpog_grid_mem #(.AW(AW)) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .swap    (swap),
        .init    (init_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Reduce angle and find nearest table step (reciprocal multiply by 1/45)
    assign a6        = item_reg.angle_raw[15:1];
    assign a6r       = (a6 >= FULL_Q6) ? a6 - FULL_Q6 : a6;
    assign scaled    = (30'(a6r) << TB) + 30'(FULL_Q6 / 2);
    assign step_q    = scaled[STEP_SHIFT +: 21];
    assign step_prod = 43'(step_q) * 43'(RECIP45);
    assign idx_full  = step_prod[RECIP_BITS +: TB + 1];

    // Floor shift and centre
    assign fx = 22'(px_reg >>> 31);
    assign fy = 22'(py_reg >>> 31);
    assign gx = fx + 22'(GRID_WIDTH / 2);
    assign gy = fy + 22'(GRID_HEIGHT / 2);
    assign on_grid = (gx >= 0) && (gx < 22'(GRID_WIDTH))
                  && (gy >= 0) && (gy < 22'(GRID_HEIGHT));
    assign cx = gx[XW-1:0];
    assign cy = gy[YW-1:0];

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            init_reg      <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            init_reg      <= init_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        idx_reg  <= idx_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
        inch_reg <= inch_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        out_reg  <= out_next;
    end

    // Sequence one transaction
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        phase_next     = phase_reg;
        init_next      = init_reg;
        idx_next       = idx_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        inch_next      = inch_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        rom_addr       = idx_reg;
        swap           = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = {cy, cx};
        wr_data        = 1'b1;
        rd_addr        = {item_reg.query_y[YW-1:0], item_reg.query_x[XW-1:0]};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (in_data.kind)
                        KIND_MEAS:
                        begin
                            if (in_data.distance_raw == 16'd0)
                            begin
                                out_next       = '0;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ANGLE;
                            end
                        end
                        KIND_PUBLISH:
                        begin
                            swap           = 1'b1;
                            clr_next       = '0;
                            out_next       = '0;
                            out_valid_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        KIND_READ:
                        begin
                            phase_next = 1'b0;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            out_next       = '0;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_ANGLE:
            begin
                idx_next   = idx_full[TB-1:0];
                inch_next  = (36'(item_reg.distance_raw) * 36'(INCH_Q24)) >> 10;
                phase_next = 1'b0;
                state_next = ST_TRIG;
            end
            ST_TRIG:
            begin
                // Look up sin, then cos; the table output is registered
                rom_addr = phase_reg ? TB'(idx_reg + TB'(QTR)) : idx_reg;
                if (phase_reg)
                begin
                    sin_next   = rom_data;
                    state_next = ST_MUL;
                end
                phase_next = 1'b1;
            end
            ST_MUL:
            begin
                cos_next   = rom_data;
                state_next = ST_POS;
            end
            ST_POS:
            begin
                px_next    = $signed({1'b0, inch_reg}) * cos_reg;
                py_next    = $signed({1'b0, inch_reg}) * sin_reg;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                out_next = '0;
                if (on_grid)
                begin
                    wr_en           = 1'b1;
                    out_next.marked = 1'b1;
                    out_next.cell_x = 8'(gx);
                    out_next.cell_y = 8'(gy);
                end
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg[AW-1:0];
                wr_data  = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW + 1)'(CELLS - 1))
                begin
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    out_next   = '0;
                    out_next.occupied = rd_data
                        && ({1'b0, item_reg.query_x} < 9'(GRID_WIDTH))
                        && ({1'b0, item_reg.query_y} < 9'(GRID_HEIGHT));
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result never carries both a mark and a read bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.marked && out_data.occupied))
        else $error("mark and read both set");

    // No input is taken while the working bank clears
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("input taken during clear");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped under stall");

endmodule

`default_nettype wire

FILE: test/grid_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// grid_checker
// Watches both channels of the lidar occupancy grid and predicts every result.
// It keeps its own working and visible grids and its own quarter-wave sine
// table. Each output transaction is compared field by field with the oldest
// prediction.
//------------------------------------------------------------------------------
`default_nettype none

module grid_checker
    import lpog_pkg::*;
#(
    parameter int GRID_WIDTH      = 64,
    parameter int GRID_HEIGHT     = 64,
    parameter int TRIG_TABLE_BITS = 10
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire in_item_t  in_data,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire out_item_t out_data,
    output int             errors,
    output int             pending
);

    localparam int CELLS   = GRID_WIDTH * GRID_HEIGHT;
    localparam int TABLE_N = 1 << TRIG_TABLE_BITS;
    localparam int QTR     = TABLE_N / 4;

    logic         work_cells [CELLS];
    logic         shown_cells[CELLS];
    longint       quarter_wave[QTR + 1];
    out_item_t    expected_q[$];

    // Quarter-wave sine in Q15 from the Q30 odd polynomial.
    function automatic longint wave_point(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] q;
        x  = (64'(k) << 30) / 64'(QTR);
        x2 = (x * x) >> 30;
        p  = 64'd85569306 - ((x2 * 64'd5026994) >> 30);
        p  = 64'd693598668 - ((x2 * p) >> 30);
        p  = 64'd1686629713 - ((x2 * p) >> 30);
        s  = (x * p) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return longint'(q);
    endfunction

    function automatic longint sine_at(input int i);
        int quad;
        int r;
        i    = i & (TABLE_N - 1);
        quad = i / QTR;
        r    = i % QTR;
        case (quad)
            0:       return quarter_wave[r];
            1:       return quarter_wave[QTR - r];
            2:       return -quarter_wave[r];
            default: return -quarter_wave[QTR - r];
        endcase
    endfunction

    // Floor division by 2^31, rounding toward minus infinity.
    function automatic longint floor_q31(input longint v);
        return v >>> 31;
    endfunction

    // Apply one input transaction to the grids and return its result.
    function automatic out_item_t grid_update(input in_item_t item);
        out_item_t res;
        longint    a6;
        longint    idx;
        longint    inches;
        longint    px;
        longint    py;
        res = '0;
        case (kind_t'(item.kind))
            KIND_MEAS:
            begin
                if (item.distance_raw != 0)
                begin
                    a6 = longint'(item.angle_raw >> 1);
                    if (a6 >= 23040)
                    begin
                        a6 = a6 - 23040;
                    end
                    idx    = ((a6 << TRIG_TABLE_BITS) + 11520) / 23040;
                    inches = (longint'(item.distance_raw) * 660519) >> 10;
                    px = floor_q31(inches * sine_at(int'(idx) + QTR)) + GRID_WIDTH / 2;
                    py = floor_q31(inches * sine_at(int'(idx))) + GRID_HEIGHT / 2;
                    if (px >= 0 && px < GRID_WIDTH && py >= 0 && py < GRID_HEIGHT)
                    begin
                        work_cells[py * GRID_WIDTH + px] = 1'b1;
                        res.marked = 1'b1;
                        res.cell_x = px[7:0];
                        res.cell_y = py[7:0];
                    end
                end
            end
            KIND_PUBLISH:
            begin
                for (int c = 0; c < CELLS; c++)
                begin
                    shown_cells[c] = work_cells[c];
                    work_cells[c]  = 1'b0;
                end
            end
            KIND_READ:
            begin
                if (item.query_x < GRID_WIDTH && item.query_y < GRID_HEIGHT)
                begin
                    res.occupied = shown_cells[item.query_y * GRID_WIDTH + item.query_x];
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        for (int k = 0; k <= QTR; k++)
        begin
            quarter_wave[k] = wave_point(k);
        end
        for (int c = 0; c < CELLS; c++)
        begin
            work_cells[c]  = 1'b0;
            shown_cells[c] = 1'b0;
        end
    end

    assign pending = expected_q.size();

    // Predict on input transactions, compare on output transactions.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && in_valid && in_ready)
        begin
            expected_q.push_back(grid_update(in_data));
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected transaction", 1, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.marked != want.marked)
                    report_mismatch("marked", out_data.marked, want.marked);
                if (out_data.cell_x != want.cell_x)
                    report_mismatch("cell_x", out_data.cell_x, want.cell_x);
                if (out_data.cell_y != want.cell_y)
                    report_mismatch("cell_y", out_data.cell_y, want.cell_y);
                if (out_data.occupied != want.occupied)
                    report_mismatch("occupied", out_data.occupied, want.occupied);
            end
        end
    end

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the lidar occupancy grid.
// Directed samples cover distance and angle extremes, off-grid hits, repeated
// hits, publishes and edge reads; then random scans of samples, publishes and
// reads run under random sender bursts and receiver stalls.
//------------------------------------------------------------------------------
`default_nettype none

module testbench;
    import lpog_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        errors;
    int        pending;
    logic      stall_on;

    lidar_polar_occupancy_grid DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    grid_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Send one transaction; hold valid until it is accepted.
    task automatic send_item(input in_item_t item);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic gap_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic in_item_t make_item(input kind_t k, input int ang,
                                            input int range_q, input int qx, input int qy);
        in_item_t it;
        it.kind         = k;
        it.angle_raw    = ang[15:0];
        it.distance_raw = range_q[15:0];
        it.query_x      = qx[7:0];
        it.query_y      = qy[7:0];
        return it;
    endfunction

    // Random sample: mostly ranges up to 20000, otherwise any 16-bit range.
    function automatic in_item_t random_sample();
        int range_q;
        if ($urandom_range(9) < 8)
        begin
            range_q = $urandom_range(20000);
        end
        else
        begin
            range_q = $urandom_range(65535);
        end
        return make_item(KIND_MEAS, $urandom_range(65535), range_q,
                         $urandom_range(255), $urandom_range(255));
    endfunction

    // Receiver stalls in runs, with quiet stretches without any stall.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_on)
        begin
            out_ready <= ($urandom_range(3) != 0);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        stall_on = 1'b1;
        forever
        begin
            repeat ($urandom_range(400, 40)) @(posedge clk);
            stall_on = ~stall_on;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int       burst;
        in_item_t it;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, off-grid, repeated hits, kinds, edge reads.
        send_item(make_item(KIND_MEAS, 0, 0, 0, 0));
        send_item(make_item(KIND_MEAS, 0, 1, 0, 0));
        send_item(make_item(KIND_MEAS, 0, 1, 0, 0));
        send_item(make_item(KIND_MEAS, 65535, 65535, 255, 255));
        send_item(make_item(KIND_MEAS, 46081, 8000, 0, 0));
        send_item(make_item(KIND_MEAS, 11520, 8000, 0, 0));
        send_item(make_item(KIND_MEAS, 23040, 8000, 0, 0));
        send_item(make_item(KIND_MEAS, 34560, 8000, 0, 0));
        send_item(make_item(KIND_MEAS, 46080, 16000, 0, 0));
        send_item(make_item(KIND_MEAS, 5760, 25000, 0, 0));
        send_item(make_item(KIND_MEAS, 1, 3000, 0, 0));
        send_item(make_item(KIND_NONE, 65535, 65535, 255, 255));
        send_item(make_item(KIND_READ, 0, 0, 32, 32));
        send_item(make_item(KIND_PUBLISH, 0, 0, 0, 0));
        send_item(make_item(KIND_READ, 0, 0, 32, 32));
        send_item(make_item(KIND_READ, 0, 0, 63, 63));
        send_item(make_item(KIND_READ, 0, 0, 64, 0));
        send_item(make_item(KIND_READ, 0, 0, 0, 64));
        send_item(make_item(KIND_READ, 65535, 65535, 255, 255));
        send_item(make_item(KIND_READ, 0, 0, 0, 0));
        send_item(make_item(KIND_PUBLISH, 65535, 65535, 255, 255));
        send_item(make_item(KIND_READ, 0, 0, 32, 32));

        // Hold off until every result has come back.
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end

        // Random scans in bursts; samples, publishes and reads are mixed at random.
        for (int n = 0; n < 750; )
        begin
            burst = $urandom_range(12, 1);
            for (int b = 0; b < burst; b++)
            begin
                case ($urandom_range(19))
                    0:       it = make_item(KIND_PUBLISH, $urandom_range(65535),
                                            $urandom_range(65535), $urandom_range(255),
                                            $urandom_range(255));
                    1, 2, 3: it = make_item(KIND_READ, $urandom_range(65535),
                                            $urandom_range(65535), $urandom_range(70),
                                            $urandom_range(70));
                    4:       it = make_item(KIND_READ, 0, 0, $urandom_range(255),
                                            $urandom_range(255));
                    5:       it = make_item(KIND_NONE, $urandom_range(65535),
                                            $urandom_range(65535), $urandom_range(255),
                                            $urandom_range(255));
                    default: it = random_sample();
                endcase
                send_item(it);
                n++;
            end
            if ($urandom_range(3) == 0)
            begin
                gap_cycles($urandom_range(30, 1));
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (50) @(negedge clk);
        if (errors == 0)
        begin
            $display("[lidar_polar_occupancy_grid] OK");
        end
        else
        begin
            $display("[lidar_polar_occupancy_grid] ERROR");
        end
        $finish;
    end

    // Guard against a hang: ~800 items, clears of all 4096 cells, stalls.
    initial
    begin
        #20ms;
        $display("[lidar_polar_occupancy_grid] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/lpog_pkg.sv
rtl/lpog_trig_rom.sv
rtl/lpog_grid_mem.sv
rtl/lidar_polar_occupancy_grid.sv
test/grid_checker.sv
test/testbench.sv
